// ----- sv/egbrf_pkg.sv -----
// Shared types, widths and command codes for the element-granular byte ring FIFO.
`timescale 1ns / 1ps

package egbrf_pkg;

   localparam int CNT_W     = 11;
   localparam int CNT_MAX   = (1 << CNT_W) - 1;
   localparam int REQ_W     = 16;
   localparam int DATA_W    = 8;
   localparam int CMD_W     = 2;
   localparam int STAT_W    = 2;
   localparam int CSR_IDX_W = 1;

   typedef logic [CNT_W-1:0]     count_type;
   typedef logic [REQ_W-1:0]     req_count_type;
   typedef logic [DATA_W-1:0]    byte_type;
   typedef logic [CMD_W-1:0]     cmd_type;
   typedef logic [STAT_W-1:0]    status_type;
   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   localparam cmd_type CMD_ENQ_GRANT = 2'd0;
   localparam cmd_type CMD_PUSH      = 2'd1;
   localparam cmd_type CMD_DEQ_GRANT = 2'd2;
   localparam cmd_type CMD_POP       = 2'd3;

   localparam status_type STAT_OK      = 2'd0;
   localparam status_type STAT_REFUSED = 2'd1;
   localparam status_type STAT_OUTSIDE = 2'd2;

   localparam csr_index_type CSR_CAPACITY = 1'd0;
   localparam csr_index_type CSR_ELEMENT  = 1'd1;

   localparam count_type CAP_RESET  = 11'd1024;
   localparam count_type ELEM_RESET = 11'd1;

   // Start of a trim job and its answer.
   typedef struct packed {
      logic      start;
      count_type value;
      count_type divisor;
   } trim_req_type;

   typedef struct packed {
      logic      done;
      count_type trimmed;
   } trim_rsp_type;

endpackage

// ----- sv/egbrf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module egbrf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- sv/egbrf_trim.sv -----
// Bit-serial remainder unit that trims a byte count down to a multiple of the element size.
`timescale 1ns / 1ps

module egbrf_trim (
   input  logic                   clock,
   input  logic                   reset,
   input  egbrf_pkg::trim_req_type trim_req,
   output egbrf_pkg::trim_rsp_type trim_rsp
);
   import egbrf_pkg::*;

   localparam int STEP_W = $clog2(CNT_W);

   logic              busy_ff,  busy_in;
   logic              done_ff,  done_in;
   logic [STEP_W-1:0] step_ff,  step_in;
   count_type         val_ff,   val_in;
   count_type         shift_ff, shift_in;
   count_type         div_ff,   div_in;
   count_type         rem_ff,   rem_in;

   logic [CNT_W:0] trial;
   logic [CNT_W:0] div_ext;
   logic [CNT_W:0] trial_sub;

   // One restoring step per cycle, most significant bit first.
   always_comb begin
      trial     = {rem_ff, shift_ff[CNT_W-1]};
      div_ext   = {1'b0, div_ff};
      trial_sub = (trial >= div_ext) ? (trial - div_ext) : trial;

      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      val_in   = val_ff;
      shift_in = shift_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;

      if (trim_req.start) begin
         busy_in  = 1'b1;
         step_in  = STEP_W'(CNT_W - 1);
         val_in   = trim_req.value;
         shift_in = trim_req.value;
         div_in   = trim_req.divisor;
         rem_in   = '0;
      end else if (busy_ff) begin
         rem_in   = trial_sub[CNT_W-1:0];
         shift_in = {shift_ff[CNT_W-2:0], 1'b0};
         step_in  = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff  <= step_in;
      val_ff   <= val_in;
      shift_ff <= shift_in;
      div_ff   <= div_in;
      rem_ff   <= rem_in;
   end

   assign trim_rsp.done    = done_ff;
   assign trim_rsp.trimmed = val_ff - rem_ff;

endmodule

// ----- sv/element_granular_byte_ring_fifo.sv -----
// Top level of the element-granular byte ring FIFO with its command sequencer.
`timescale 1ns / 1ps

// The block holds a byte ring of DEPTH slots, of which cap_eff are used, and
// serves one request at a time. A push request passes through EXEC and DONE
// before the block can take the next request, a pop request through EXEC, READ
// and DONE (the ring memory has a registered read port), and an enqueue or
// dequeue grant through EXEC, DIV and DONE, where DIV waits for the remainder
// unit that trims the count to a whole number of elements one bit per cycle
// over 11 steps. A grant that is refused, and a push or pop outside a grant,
// skip that work and pass through EXEC and DONE. In DONE a finished response
// waits for rsp_ready while the response register is still full. After reset,
// and after every write to either configuration register, the block clears the
// ring memory one slot per cycle and accepts no request meanwhile; configuration
// writes are still taken and restart the pass. A grant is refused while the
// previous grant of the same kind still has bytes to move, and pushes or pops
// beyond a grant are flagged in the response status without touching the ring.
module element_granular_byte_ring_fifo #(
   parameter int DEPTH = 1024
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_ready,
   input  egbrf_pkg::cmd_type            req_command,
   input  egbrf_pkg::req_count_type      req_requested_count,
   input  egbrf_pkg::byte_type           req_data_byte,

   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output egbrf_pkg::count_type          rsp_granted_count,
   output egbrf_pkg::byte_type           rsp_data_out,
   output egbrf_pkg::status_type         rsp_status,
   output egbrf_pkg::count_type          rsp_fill_level,

   input  logic                          csr_we,
   input  egbrf_pkg::csr_index_type      csr_index,
   input  egbrf_pkg::count_type          csr_wdata
);
   import egbrf_pkg::*;

   localparam int AW    = $clog2(DEPTH);
   localparam int SUM_W = ((AW > CNT_W) ? AW : CNT_W) + 1;

   // Largest usable capacity: bounded by the ring and by the register width.
   localparam count_type CAP_MAX = (DEPTH > CNT_MAX) ? count_type'(CNT_MAX)
                                                     : CNT_W'(DEPTH);
   localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_EXEC  = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_READ  = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   // Sequencer and configuration.
   logic [2:0]    state_ff,    state_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   count_type     cap_ff,      cap_in;
   count_type     elem_ff,     elem_in;

   // Ring bookkeeping.
   logic [AW-1:0] head_ff,     head_in;
   logic [AW-1:0] tail_ff,     tail_in;
   count_type     fill_ff,     fill_in;
   logic [AW-1:0] push_pos_ff, push_pos_in;
   count_type     push_rem_ff, push_rem_in;
   logic [AW-1:0] pop_pos_ff,  pop_pos_in;
   count_type     pop_rem_ff,  pop_rem_in;

   // The request being served.
   cmd_type       cmd_ff,      cmd_in;
   req_count_type req_cnt_ff,  req_cnt_in;
   byte_type      data_ff,     data_in;

   // Result under construction.
   count_type     res_granted_ff, res_granted_in;
   byte_type      res_data_ff,    res_data_in;
   status_type    res_status_ff,  res_status_in;

   // Response register.
   logic          rsp_valid_ff,   rsp_valid_in;
   count_type     rsp_granted_ff, rsp_granted_in;
   byte_type      rsp_data_ff,    rsp_data_in;
   status_type    rsp_status_ff,  rsp_status_in;
   count_type     rsp_fill_ff,    rsp_fill_in;

   count_type     cap_eff;
   count_type     elem_eff;
   count_type     enq_limit;
   count_type     enq_n;
   count_type     deq_n;
   count_type     grant_n;

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   byte_type      mem_wdata;
   byte_type      mem_rdata;

   trim_req_type  trim_req;
   trim_rsp_type  trim_rsp;

   // Positions stay below the capacity and a step never exceeds it, so one
   // compare and subtract wraps the sum.
   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] pos,
                                              input count_type n,
                                              input count_type cap);
      logic [SUM_W-1:0] s;
      s = SUM_W'(pos) + SUM_W'(n);
      if (s >= SUM_W'(cap)) begin
         s = s - SUM_W'(cap);
      end
      return AW'(s);
   endfunction

   // A capacity of zero behaves as one, one beyond the ring as the ring size,
   // and an element size of zero as one byte.
   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = CNT_W'(1);
      end else if (cap_ff > CAP_MAX) begin
         cap_eff = CAP_MAX;
      end else begin
         cap_eff = cap_ff;
      end
      elem_eff = (elem_ff == '0) ? CNT_W'(1) : elem_ff;
   end

   // Untrimmed grant sizes: clamp to free space or to the fill level.
   assign enq_limit = cap_eff - fill_ff;
   assign enq_n     = (REQ_W'(enq_limit) > req_cnt_ff) ? req_cnt_ff[CNT_W-1:0] : enq_limit;
   assign deq_n     = (REQ_W'(fill_ff) > req_cnt_ff) ? req_cnt_ff[CNT_W-1:0] : fill_ff;
   assign grant_n   = (cmd_ff == CMD_ENQ_GRANT) ? enq_n : deq_n;

   always_comb begin
      state_in       = state_ff;
      clr_addr_in    = clr_addr_ff;
      cap_in         = cap_ff;
      elem_in        = elem_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      fill_in        = fill_ff;
      push_pos_in    = push_pos_ff;
      push_rem_in    = push_rem_ff;
      pop_pos_in     = pop_pos_ff;
      pop_rem_in     = pop_rem_ff;
      cmd_in         = cmd_ff;
      req_cnt_in     = req_cnt_ff;
      data_in        = data_ff;
      res_granted_in = res_granted_ff;
      res_data_in    = res_data_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_fill_in    = rsp_fill_ff;

      mem_we    = 1'b0;
      mem_waddr = push_pos_ff;
      mem_wdata = data_ff;

      trim_req.start   = 1'b0;
      trim_req.value   = grant_n;
      trim_req.divisor = elem_eff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            // Zero the ring one slot per cycle.
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            mem_wdata   = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in     = req_command;
               req_cnt_in = req_requested_count;
               data_in    = req_data_byte;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            res_granted_in = '0;
            res_data_in    = '0;
            res_status_in  = STAT_OK;
            state_in       = ST_DONE;
            case (cmd_ff)
               CMD_ENQ_GRANT: begin
                  if (push_rem_ff != '0) begin
                     res_status_in = STAT_REFUSED;
                  end else begin
                     trim_req.start = 1'b1;
                     state_in       = ST_DIV;
                  end
               end
               CMD_DEQ_GRANT: begin
                  if (pop_rem_ff != '0) begin
                     res_status_in = STAT_REFUSED;
                  end else begin
                     trim_req.start = 1'b1;
                     state_in       = ST_DIV;
                  end
               end
               CMD_PUSH: begin
                  if (push_rem_ff == '0) begin
                     res_status_in = STAT_OUTSIDE;
                  end else begin
                     mem_we      = 1'b1;
                     push_pos_in = wrap_add(push_pos_ff, CNT_W'(1), cap_eff);
                     push_rem_in = push_rem_ff - 1'b1;
                  end
               end
               default: begin
                  if (pop_rem_ff == '0) begin
                     res_status_in = STAT_OUTSIDE;
                  end else begin
                     // The read of pop_pos_ff is under way; data arrives next cycle.
                     pop_pos_in = wrap_add(pop_pos_ff, CNT_W'(1), cap_eff);
                     pop_rem_in = pop_rem_ff - 1'b1;
                     state_in   = ST_READ;
                  end
               end
            endcase
         end
         ST_DIV: begin
            if (trim_rsp.done) begin
               state_in = ST_DONE;
               if (trim_rsp.trimmed != '0) begin
                  res_granted_in = trim_rsp.trimmed;
                  if (cmd_ff == CMD_ENQ_GRANT) begin
                     push_pos_in = tail_ff;
                     push_rem_in = trim_rsp.trimmed;
                     tail_in     = wrap_add(tail_ff, trim_rsp.trimmed, cap_eff);
                     fill_in     = fill_ff + trim_rsp.trimmed;
                  end else begin
                     pop_pos_in  = head_ff;
                     pop_rem_in  = trim_rsp.trimmed;
                     head_in     = wrap_add(head_ff, trim_rsp.trimmed, cap_eff);
                     fill_in     = fill_ff - trim_rsp.trimmed;
                  end
               end
            end
         end
         ST_READ: begin
            res_data_in = mem_rdata;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = res_granted_ff;
               rsp_data_in    = res_data_ff;
               rsp_status_in  = res_status_ff;
               rsp_fill_in    = fill_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            clr_addr_in = '0;
            state_in    = ST_CLEAR;
         end
      endcase

      // A register write empties the FIFO and starts a fresh clearing pass.
      if (csr_we) begin
         unique case (csr_index)
            CSR_CAPACITY: cap_in  = csr_wdata;
            CSR_ELEMENT:  elem_in = csr_wdata;
         endcase
         head_in     = '0;
         tail_in     = '0;
         fill_in     = '0;
         push_pos_in = '0;
         push_rem_in = '0;
         pop_pos_in  = '0;
         pop_rem_in  = '0;
         clr_addr_in = '0;
         state_in    = ST_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         cap_ff       <= CAP_RESET;
         elem_ff      <= ELEM_RESET;
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         push_pos_ff  <= '0;
         push_rem_ff  <= '0;
         pop_pos_ff   <= '0;
         pop_rem_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         cap_ff       <= cap_in;
         elem_ff      <= elem_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         push_pos_ff  <= push_pos_in;
         push_rem_ff  <= push_rem_in;
         pop_pos_ff   <= pop_pos_in;
         pop_rem_ff   <= pop_rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff         <= cmd_in;
      req_cnt_ff     <= req_cnt_in;
      data_ff        <= data_in;
      res_granted_ff <= res_granted_in;
      res_data_ff    <= res_data_in;
      res_status_ff  <= res_status_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_fill_ff    <= rsp_fill_in;
   end

   egbrf_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (pop_pos_ff),
      .rd_data (mem_rdata)
   );

   egbrf_trim u_trim (
      .clock    (clock),
      .reset    (reset),
      .trim_req (trim_req),
      .trim_rsp (trim_rsp)
   );

   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_granted_count = rsp_granted_ff;
   assign rsp_data_out      = rsp_data_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_fill_level    = rsp_fill_ff;

`ifndef NO_ASSERTIONS
   // Reservations never exceed the usable capacity.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= cap_eff)
      else $error("fill level exceeds capacity");

   // Head and tail meet exactly when the ring is empty or full.
   a_head_tail: assert property (@(posedge clock) disable iff (reset)
      ((fill_ff == '0) || (fill_ff == cap_eff)) == (head_ff == tail_ff))
      else $error("head and tail disagree with fill level");

   // A trimmed grant never exceeds the clamped request it came from.
   a_trim_bound: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DIV) && trim_rsp.done) |-> (trim_rsp.trimmed <= grant_n))
      else $error("trimmed grant exceeds clamped request");

   // A refused enqueue grant leaves the fill level and the tail untouched.
   a_refused_stable: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_EXEC) && (cmd_ff == CMD_ENQ_GRANT) && (push_rem_ff != '0)
       && !csr_we) |=> ($stable(fill_ff) && $stable(tail_ff)))
      else $error("refused grant changed the ring");
`endif

endmodule

// ----- tb/sv/element_granular_byte_ring_fifo_test.sv -----
// Self-checking testbench for the element-granular byte ring FIFO.
`timescale 1ns / 1ps

// The testbench keeps its own copy of the ring: the configuration, the byte
// store, the head, tail, push and pop positions and the counts still owed to
// open grants. Every request that the block accepts is applied to that copy.
// The response it yields is queued and compared field by field with the next
// response the block hands over.
//
// The stimulus is built in phases. Each phase writes both registers, which
// empties the FIFO and starts the block's clearing pass. It then pushes a
// backlog of loose requests while the receiver holds off for a long stretch,
// so that the block fills up and stops taking requests. After that it mostly
// runs well-formed sequences: a grant, and then as many pushes or pops as the
// grant opened. Sometimes it moves fewer bytes, so that later grants are
// refused, or a byte or two more, so that the extra ones fall outside the
// grant. A short directed part runs first.
module element_granular_byte_ring_fifo_test;
   import egbrf_pkg::*;

   localparam int RING_DEPTH   = 1024;
   localparam int NUM_PHASES   = 12;
   localparam int PHASE_BUDGET = 140;
   localparam int HOLD_CYCLES  = 300;
   localparam int MAX_PRINTS   = 100;

   typedef struct packed {
      cmd_type       command;
      req_count_type amount;
      byte_type      payload;
   } fifo_request_type;

   typedef struct packed {
      count_type  granted;
      byte_type   data;
      status_type status;
      count_type  fill;
   } fifo_response_type;

   // Clock, reset and the ports of the block. Every input has a known value
   // from time zero.
   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   cmd_type       req_command = CMD_ENQ_GRANT;
   req_count_type req_requested_count = '0;
   byte_type      req_data_byte = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   count_type     rsp_granted_count;
   byte_type      rsp_data_out;
   status_type    rsp_status;
   count_type     rsp_fill_level;
   logic          csr_we = 1'b0;
   csr_index_type csr_index = CSR_CAPACITY;
   count_type     csr_wdata = '0;

   always #5 clock = ~clock;

   element_granular_byte_ring_fifo #(.DEPTH(RING_DEPTH)) DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_command         (req_command),
      .req_requested_count (req_requested_count),
      .req_data_byte       (req_data_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_granted_count   (rsp_granted_count),
      .rsp_data_out        (rsp_data_out),
      .rsp_status          (rsp_status),
      .rsp_fill_level      (rsp_fill_level),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   // Requests waiting for the driver and responses the block still owes.
   fifo_request_type  pending_requests[$];
   fifo_response_type fifo_responses_due[$];

   // The testbench's copy of the ring and its configuration.
   count_type  cfg_capacity;
   count_type  cfg_element;
   byte_type   ring_copy [RING_DEPTH];
   logic [9:0] head_at, tail_at, push_at, pop_at;
   count_type  fill_now, push_left, pop_left;

   // Tallies for the closing summary, and the mismatch count.
   int unsigned sent_count, responses_seen, mismatches, settings_used, holdoffs;
   int unsigned grants_given, grants_empty, grants_refused, moves_outside;

   // Handshake between the stimulus and the receiver for the long hold-off.
   logic hold_wanted = 1'b0;
   int   queued;

   // A capacity of zero counts as one slot, and anything past the ring counts
   // as the whole ring.
   function automatic int unsigned ring_span();
      if (cfg_capacity == 0) begin
         return 1;
      end
      if (cfg_capacity > RING_DEPTH) begin
         return RING_DEPTH;
      end
      return cfg_capacity;
   endfunction

   // An element size of zero means that grants are not trimmed at all.
   function automatic int unsigned grain_span();
      return (cfg_element == 0) ? 1 : cfg_element;
   endfunction

   function automatic int unsigned ring_step(int unsigned pos, int unsigned n,
                                             int unsigned span);
      int unsigned s;
      s = pos % span + n % span;
      return (s >= span) ? s - span : s;
   endfunction

   // A register write, like a reset, drops everything in flight and zeroes
   // the store.
   function automatic void empty_ring_copy();
      for (int i = 0; i < RING_DEPTH; i++) begin
         ring_copy[i] = '0;
      end
      head_at   = '0;
      tail_at   = '0;
      push_at   = '0;
      pop_at    = '0;
      fill_now  = '0;
      push_left = '0;
      pop_left  = '0;
   endfunction

   // Applies one accepted request to the copy of the ring and queues the
   // response that the block must give for it.
   function automatic void predict_fifo_response(fifo_request_type rq);
      int unsigned       span, grain, n, ask;
      fifo_response_type r;
      span  = ring_span();
      grain = grain_span();
      ask   = rq.amount;
      r     = '0;
      if (fill_now > span) begin
         fill_now = count_type'(span);
      end
      case (rq.command)
         CMD_ENQ_GRANT: begin
            if (push_left != 0) begin
               r.status = STAT_REFUSED;
            end else begin
               // Clamp to the free space, then trim to whole elements.
               n = span - fill_now;
               if (ask < n) begin
                  n = ask;
               end
               n -= n % grain;
               if (n != 0) begin
                  push_at   = 10'(tail_at % span);
                  push_left = count_type'(n);
                  tail_at   = 10'(ring_step(tail_at, n, span));
                  fill_now  = count_type'(fill_now + n);
                  r.granted = count_type'(n);
               end
            end
         end
         CMD_PUSH: begin
            if (push_left == 0) begin
               r.status = STAT_OUTSIDE;
            end else begin
               push_at            = 10'(push_at % span);
               ring_copy[push_at] = rq.payload;
               push_at            = 10'(ring_step(push_at, 1, span));
               push_left          = push_left - 1'b1;
            end
         end
         CMD_DEQ_GRANT: begin
            if (pop_left != 0) begin
               r.status = STAT_REFUSED;
            end else begin
               // The fill level counts reserved bytes, so this grant may
               // cover slots whose pushes have not happened yet.
               n = fill_now;
               if (ask < n) begin
                  n = ask;
               end
               n -= n % grain;
               if (fill_now != 0 && n != 0) begin
                  pop_at    = 10'(head_at % span);
                  pop_left  = count_type'(n);
                  head_at   = 10'(ring_step(head_at, n, span));
                  fill_now  = count_type'(fill_now - n);
                  r.granted = count_type'(n);
               end
            end
         end
         CMD_POP: begin
            if (pop_left == 0) begin
               r.status = STAT_OUTSIDE;
            end else begin
               pop_at   = 10'(pop_at % span);
               r.data   = ring_copy[pop_at];
               pop_at   = 10'(ring_step(pop_at, 1, span));
               pop_left = pop_left - 1'b1;
            end
         end
         default: ;
      endcase
      r.fill = fill_now;
      fifo_responses_due.push_back(r);

      if (r.status == STAT_REFUSED) begin
         grants_refused++;
      end else if (r.status == STAT_OUTSIDE) begin
         moves_outside++;
      end else if (rq.command == CMD_ENQ_GRANT || rq.command == CMD_DEQ_GRANT) begin
         if (r.granted != 0) begin
            grants_given++;
         end else begin
            grants_empty++;
         end
      end
   endfunction

   task automatic report_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTS) begin
         $display("mismatch at response %0d: %s", responses_seen, msg);
      end
   endtask

   // Sender: hands out queued requests in bursts of random length with random
   // gaps between them. Once valid is raised, it holds along with the payload
   // until the block takes the request. The copy of the ring advances at the
   // same edge at which the block accepts the request.
   int unsigned burst_left = 0;
   int unsigned gap_left   = 0;

   always @(posedge clock) begin : drive_requests
      fifo_request_type next_rq;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_fifo_response('{command: req_command, amount: req_requested_count,
                                    payload: req_data_byte});
            sent_count++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
               next_rq = pending_requests.pop_front();
               req_valid           <= 1'b1;
               req_command         <= next_rq.command;
               req_requested_count <= next_rq.amount;
               req_data_byte       <= next_rq.payload;
               if (burst_left <= 1) begin
                  // A third of the bursts run straight into the next one.
                  burst_left = $urandom_range(1, 32);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: switches between runs that are always ready, runs that are
   // mostly ready and runs that are mostly stalled. When the stimulus asks
   // for it, it also holds off for a long stretch, counted here.
   int unsigned hold_left  = 0;
   int unsigned ready_run  = 0;
   int unsigned ready_mode = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (hold_wanted) begin
            hold_wanted = 1'b0;
            hold_left   = HOLD_CYCLES;
            holdoffs++;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (ready_run == 0) begin
               ready_mode = $urandom_range(0, 2);
               ready_run  = $urandom_range(4, 40);
            end
            ready_run--;
            case (ready_mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 3) != 0);
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // Checker: each response the block hands over must match the oldest one
   // that is still owed.
   always @(posedge clock) begin : check_responses
      fifo_response_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         responses_seen++;
         if (fifo_responses_due.size() == 0) begin
            report_mismatch("response arrived with none owed");
         end else begin
            want = fifo_responses_due.pop_front();
            if (rsp_granted_count !== want.granted) begin
               report_mismatch($sformatf("granted_count %0d, expected %0d",
                                         rsp_granted_count, want.granted));
            end
            if (rsp_data_out !== want.data) begin
               report_mismatch($sformatf("data_out %0h, expected %0h",
                                         rsp_data_out, want.data));
            end
            if (rsp_status !== want.status) begin
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_status, want.status));
            end
            if (rsp_fill_level !== want.fill) begin
               report_mismatch($sformatf("fill_level %0d, expected %0d",
                                         rsp_fill_level, want.fill));
            end
         end
      end
   end

   // Grant sizes are mostly small, a few elements at most, so that big rings
   // still see a good mix. A few requests ask for everything or use the full
   // width of the field.
   function automatic req_count_type pick_amount();
      int unsigned lim;
      lim = 2 * ring_span();
      if (lim > 3 * grain_span() + 8) begin
         lim = 3 * grain_span() + 8;
      end
      case ($urandom_range(0, 19))
         0: return 16'($urandom);
         1: return 16'hFFFF;
         2: return '0;
         default: return 16'($urandom_range(1, lim));
      endcase
   endfunction

   task automatic offer(cmd_type cmd, req_count_type amount, byte_type payload);
      pending_requests.push_back('{command: cmd, amount: amount, payload: payload});
      queued++;
   endtask

   task automatic offer_loose();
      offer(cmd_type'($urandom_range(CMD_ENQ_GRANT, CMD_POP)), pick_amount(),
            8'($urandom));
   endtask

   // The copy of the ring is up to date once the driver has nothing left to
   // hand over.
   task automatic wait_accepted();
      @(negedge clock);
      while (pending_requests.size() != 0 || req_valid) begin
         @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (pending_requests.size() != 0 || req_valid || fifo_responses_due.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic write_csr(csr_index_type idx, count_type value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_CAPACITY) begin
         cfg_capacity = value;
      end else begin
         cfg_element = value;
      end
      empty_ring_copy();
   endtask

   task automatic run_phase(count_type cap, count_type grain, int budget);
      int  pick, k, n;
      logic filling;
      wait_drained();
      write_csr(CSR_CAPACITY, cap);
      write_csr(CSR_ELEMENT, grain);
      settings_used++;
      queued = 0;

      // A backlog is offered while the receiver holds off, so that the
      // block's response path backs up into its request port.
      repeat (16) offer_loose();
      hold_wanted = 1'b1;

      while (queued < budget) begin
         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            filling = (pick < 42);
            offer(filling ? CMD_ENQ_GRANT : CMD_DEQ_GRANT, pick_amount(), 8'($urandom));
            wait_accepted();
            n = filling ? push_left : pop_left;
            case ($urandom_range(0, 9))
               0: k = $urandom_range(0, n);
               1: k = n + $urandom_range(1, 2);
               default: k = n;
            endcase
            if (k > budget - queued + 4) begin
               k = budget - queued + 4;
            end
            repeat (k) begin
               offer(filling ? CMD_PUSH : CMD_POP, 16'($urandom), 8'($urandom));
            end
         end else begin
            repeat ($urandom_range(1, 4)) offer_loose();
         end
      end
   endtask

   // The settings run from the degenerate ones (a single slot, a capacity of
   // zero, an element size of zero, or a value past the ring) to the full ring.
   count_type phase_caps [NUM_PHASES] = '{11'd5, 11'd1, 11'd0, 11'd2047, 11'd1024, 11'd7,
                                          11'd16, 11'd3, 11'd100, 11'd1024, 11'd13, 11'd2};
   count_type phase_grains [NUM_PHASES] = '{11'd2, 11'd1, 11'd5, 11'd0, 11'd1024, 11'd3,
                                            11'd4, 11'd0, 11'd7, 11'd1, 11'd2047, 11'd2};

   initial begin
      cfg_capacity = CAP_RESET;
      cfg_element  = ELEM_RESET;
      empty_ring_copy();
      settings_used = 1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part with the reset settings of 1024 slots and 1-byte
      // elements: moves outside any grant, a dequeue from an empty FIFO, a
      // grant refused while one is pending, and a dequeue grant that covers a
      // byte not yet pushed, so its pop returns the cleared slot.
      offer(CMD_POP, 16'd0, 8'h00);
      offer(CMD_PUSH, 16'hFFFF, 8'h5A);
      offer(CMD_DEQ_GRANT, 16'd5, 8'h00);
      offer(CMD_ENQ_GRANT, 16'd3, 8'hFF);
      offer(CMD_ENQ_GRANT, 16'd7, 8'h00);
      offer(CMD_PUSH, 16'd0, 8'h00);
      offer(CMD_PUSH, 16'd0, 8'hFF);
      offer(CMD_DEQ_GRANT, 16'd3, 8'h00);
      offer(CMD_DEQ_GRANT, 16'd1, 8'h00);
      offer(CMD_POP, 16'd0, 8'h00);
      offer(CMD_POP, 16'd0, 8'h00);
      offer(CMD_POP, 16'd0, 8'h00);
      offer(CMD_PUSH, 16'd0, 8'hA5);
      offer(CMD_POP, 16'd0, 8'h00);

      // Five slots of 2-byte elements: the largest request is clamped to the
      // free space and trimmed to 4, a request for the last free byte trims
      // to nothing, and the ring is then drained.
      wait_drained();
      write_csr(CSR_CAPACITY, 11'd5);
      write_csr(CSR_ELEMENT, 11'd2);
      settings_used++;
      offer(CMD_ENQ_GRANT, 16'hFFFF, 8'h00);
      offer(CMD_PUSH, 16'd0, 8'h01);
      offer(CMD_PUSH, 16'd0, 8'h80);
      offer(CMD_PUSH, 16'd0, 8'h7F);
      offer(CMD_PUSH, 16'd0, 8'hFE);
      offer(CMD_ENQ_GRANT, 16'd1, 8'h00);
      offer(CMD_DEQ_GRANT, 16'hFFFF, 8'h00);
      repeat (4) offer(CMD_POP, 16'd0, 8'h00);

      for (int p = 0; p < NUM_PHASES; p++) begin
         run_phase(phase_caps[p], phase_grains[p], PHASE_BUDGET);
      end

      // Let the block settle, then catch anything still owed or any late
      // extra response.
      wait_drained();
      repeat (40) @(posedge clock);
      if (fifo_responses_due.size() != 0) begin
         report_mismatch($sformatf("%0d responses never arrived", fifo_responses_due.size()));
      end

      $display("summary: %0d requests under %0d register settings, %0d responses checked,",
               sent_count, settings_used, responses_seen);
      $display("summary: %0d long hold-offs, %0d grants given, %0d trimmed to nothing,",
               holdoffs, grants_given, grants_empty);
      $display("summary: %0d grants refused, %0d moves outside a grant",
               grants_refused, moves_outside);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Guard against a hung handshake. This allows for the clearing pass after
   // each register write and the slowest mix of stalls, several times over.
   initial begin
      #8000000;
      $display("tb: failure");
      $finish;
   end

endmodule

// ----- element_granular_byte_ring_fifo.f -----
sv/egbrf_pkg.sv
sv/egbrf_ram.sv
sv/egbrf_trim.sv
sv/element_granular_byte_ring_fifo.sv
tb/sv/element_granular_byte_ring_fifo_test.sv
